// ===== rtl/wsrq_pkg.sv =====
`timescale 1ns / 1ps
package wsrq_pkg;

  localparam int NUM_PROCS    = 4;
  localparam int LOCAL_DEPTH  = 256;
  localparam int GLOBAL_DEPTH = 1024;
  localparam int TASK_BITS    = 16;
  localparam int FAIR_PERIOD  = 61;

  localparam int PROC_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int NP_W    = $clog2(NUM_PROCS + 1);
  localparam int LOC_W   = $clog2(LOCAL_DEPTH);
  localparam int POS_W   = LOC_W + 1;
  localparam int HALF_W  = LOC_W - 1;
  localparam int LADDR_W = PROC_W + LOC_W;
  localparam int G_AW    = $clog2(GLOBAL_DEPTH);
  localparam int GCNT_W  = G_AW + 1;
  localparam int TICK_W  = $clog2(FAIR_PERIOD);

  localparam logic [1:0] ACT_PUSH_LOCAL  = 2'd0;
  localparam logic [1:0] ACT_FETCH       = 2'd1;
  localparam logic [1:0] ACT_PUSH_GLOBAL = 2'd2;

  localparam logic [1:0] SRC_RUNNEXT = 2'd0;
  localparam logic [1:0] SRC_LOCAL   = 2'd1;
  localparam logic [1:0] SRC_GLOBAL  = 2'd2;
  localparam logic [1:0] SRC_STOLEN  = 2'd3;

  typedef logic [TASK_BITS-1:0] task_t;

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_DISP  = 12'b0000_0000_0010,
    S_RPUT  = 12'b0000_0000_0100,
    S_SPRD  = 12'b0000_0000_1000,
    S_SPWR  = 12'b0000_0001_0000,
    S_GDATA = 12'b0000_0010_0000,
    S_XDATA = 12'b0000_0100_0000,
    S_LDATA = 12'b0000_1000_0000,
    S_STCHK = 12'b0001_0000_0000,
    S_STRD  = 12'b0010_0000_0000,
    S_STWR  = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_t;

endpackage

// ===== rtl/wsrq_ram.sv =====
`timescale 1ns / 1ps
module wsrq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/work_stealing_run_queues_core.sv =====
`timescale 1ns / 1ps
// work-stealing run queue dispatcher
// request channel: in_valid/in_ready carries action, proc, task_id, use_next.
// result channel: out_valid/out_ready carries found, out_task, source, victim,
// overflow; every request gives exactly one result.
// cfg_we/cfg_data writes active_procs (reset value 4); write it only while idle.
// one request is worked at a time by a sequencer around two rams with a
// registered read (per-processor rings and the global fifo), one write and one read port each.
//   a global fetch can also move an extra task from the global fifo into the ring;
//   a full ring spill moves LOCAL_DEPTH/2 tasks, each read in S_SPRD, written in S_SPWR;
//   S_STCHK passes over peers one at a time; a steal of n ring tasks reads each
//   in S_STRD and writes it in S_STWR, the last one being returned instead.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, so the next request may be taken while it waits.
// if out_ready stays low the sequencer holds its next result until the
// register frees up.
// reset (rst, synchronous) empties all queues, runnext slots and ticks;
// ram contents are left as they are and read only after being written.
module work_stealing_run_queues_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [2:0]                        cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        action,
  input  logic [1:0]                        proc,
  input  logic [wsrq_pkg::TASK_BITS-1:0]    task_id,
  input  logic                              use_next,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [wsrq_pkg::TASK_BITS-1:0]    out_task,
  output logic [1:0]                        source,
  output logic [1:0]                        victim,
  output logic                              overflow
);
  import wsrq_pkg::*;

  function automatic logic [PROC_W-1:0] first_victim(input logic [NP_W:0] x,
                                                     input logic [NP_W-1:0] n);
    logic [NP_W:0] r;
    r = x;
    for (int i = 0; i < NUM_PROCS; i++) begin
      if (r >= {1'b0, n}) r = r - {1'b0, n};
    end
    return r[PROC_W-1:0];
  endfunction

  state_t state;

  logic [2:0]          active_procs;
  logic [NP_W-1:0]     np;
  logic [1:0]          a_act;
  logic [PROC_W-1:0]   a_proc;
  task_t               a_task;
  logic                a_use_next;

  logic                next_valid [NUM_PROCS];
  task_t               next_task  [NUM_PROCS];
  logic [POS_W-1:0]    ring_head  [NUM_PROCS];
  logic [POS_W-1:0]    ring_tail  [NUM_PROCS];
  logic [TICK_W-1:0]   sched_tick [NUM_PROCS];
  logic [G_AW-1:0]     global_head;
  logic [GCNT_W-1:0]   global_count;

  task_t               pt;
  logic                extra;
  logic [HALF_W-1:0]   cnt;
  logic [PROC_W-1:0]   vic;
  logic [NP_W-1:0]     si;

  logic                res_found;
  task_t               res_task;
  logic [1:0]          res_src;
  logic [PROC_W-1:0]   res_vic;
  logic                dropped;

  logic [PROC_W-1:0]   qp;
  logic [POS_W-1:0]    cur_head;
  logic [POS_W-1:0]    cur_tail;
  logic [POS_W-1:0]    cur_cnt;
  logic                cur_nv;
  task_t               cur_nt;
  logic [TICK_W-1:0]   tick_inc;
  logic                gfull;
  logic                gempty;
  logic [POS_W-1:0]    steal_n;
  logic [NP_W:0]       vic_inc;

  logic                l_we;
  logic [LADDR_W-1:0]  l_wa;
  task_t               l_wd;
  logic [LADDR_W-1:0]  l_ra;
  task_t               l_rd;
  logic                g_we;
  logic [G_AW-1:0]     g_wa;
  task_t               g_wd;
  task_t               g_rd;

  always_comb begin
    if (active_procs == 3'd0) begin
      np = NP_W'(1);
    end else if (active_procs > 3'(NUM_PROCS)) begin
      np = NP_W'(NUM_PROCS);
    end else begin
      np = NP_W'(active_procs);
    end
  end

  // steal states look at the victim, everything else at the requester
  assign qp       = (state == S_STCHK || state == S_STRD) ? vic : a_proc;
  assign cur_head = ring_head[qp];
  assign cur_tail = ring_tail[qp];
  assign cur_cnt  = cur_tail - cur_head;
  assign cur_nv   = next_valid[qp];
  assign cur_nt   = next_task[qp];
  assign tick_inc = (sched_tick[qp] == TICK_W'(FAIR_PERIOD - 1)) ? '0
                                                                 : sched_tick[qp] + 1'b1;
  assign gfull    = global_count[G_AW];
  assign gempty   = (global_count == '0);
  // older half rounded up, capped at half the ring
  assign steal_n  = (cur_cnt - (cur_cnt >> 1) > POS_W'(LOCAL_DEPTH / 2))
                    ? POS_W'(LOCAL_DEPTH / 2) : cur_cnt - (cur_cnt >> 1);
  assign vic_inc  = {{(NP_W + 1 - PROC_W){1'b0}}, vic} + 1'b1;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    l_we = 1'b0;
    l_wa = {a_proc, cur_tail[LOC_W-1:0]};
    l_wd = pt;
    l_ra = {qp, cur_head[LOC_W-1:0]};
    g_we = 1'b0;
    g_wa = global_head + global_count[G_AW-1:0];
    g_wd = a_task;
    case (state)
      S_DISP: g_we = (a_act == ACT_PUSH_GLOBAL) && !gfull;
      S_RPUT: l_we = !cur_cnt[LOC_W];
      S_SPWR: begin
        g_wd = l_rd;
        g_we = !gfull;
      end
      S_STWR: begin
        l_wd = l_rd;
        l_we = (cnt != '0);
      end
      default: ;
    endcase
  end

  wsrq_ram #(.WIDTH(TASK_BITS), .DEPTH(NUM_PROCS * LOCAL_DEPTH)) u_local_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_wa),
    .wdata (l_wd),
    .raddr (l_ra),
    .rdata (l_rd)
  );

  wsrq_ram #(.WIDTH(TASK_BITS), .DEPTH(GLOBAL_DEPTH)) u_global_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_wa),
    .wdata (g_wd),
    .raddr (global_head),
    .rdata (g_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      active_procs <= 3'd4;
      global_head  <= '0;
      global_count <= '0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        next_valid[i] <= 1'b0;
        ring_head[i]  <= '0;
        ring_tail[i]  <= '0;
        sched_tick[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        active_procs <= cfg_data;
      end
      // the finishing state refills the register itself
      if (out_valid && out_ready && state != S_FIN) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a_act      <= action;
            a_proc     <= proc[PROC_W-1:0];
            a_task     <= task_id;
            a_use_next <= use_next;
            res_found  <= 1'b0;
            res_task   <= '0;
            res_src    <= '0;
            res_vic    <= '0;
            dropped    <= 1'b0;
            state      <= S_DISP;
          end
        end
        S_DISP: begin
          case (a_act)
            ACT_PUSH_LOCAL: begin
              if (a_use_next) begin
                next_valid[qp] <= 1'b1;
                next_task[qp]  <= a_task;
                pt             <= cur_nt;
                state          <= cur_nv ? S_RPUT : S_FIN;
              end else begin
                pt    <= a_task;
                state <= S_RPUT;
              end
            end
            ACT_PUSH_GLOBAL: begin
              if (gfull) begin
                dropped <= 1'b1;
              end else begin
                global_count <= global_count + 1'b1;
              end
              state <= S_FIN;
            end
            ACT_FETCH: begin
              sched_tick[qp] <= tick_inc;
              if (tick_inc == '0 && !gempty) begin
                extra        <= 1'b1;
                global_head  <= global_head + 1'b1;
                global_count <= global_count - 1'b1;
                state        <= S_GDATA;
              end else if (cur_nv) begin
                next_valid[qp] <= 1'b0;
                res_task       <= cur_nt;
                res_found      <= 1'b1;
                res_src        <= SRC_RUNNEXT;
                state          <= S_FIN;
              end else if (cur_cnt != '0) begin
                ring_head[qp] <= cur_head + 1'b1;
                state         <= S_LDATA;
              end else if (!gempty) begin
                extra        <= (a_proc == '0);
                global_head  <= global_head + 1'b1;
                global_count <= global_count - 1'b1;
                state        <= S_GDATA;
              end else if (np > NP_W'(1)) begin
                vic   <= first_victim({{(NP_W + 1 - PROC_W){1'b0}}, a_proc} + 1'b1, np);
                si    <= '0;
                state <= S_STCHK;
              end else begin
                state <= S_FIN;
              end
            end
            default: state <= S_FIN;
          endcase
        end
        S_GDATA: begin
          res_task  <= g_rd;
          res_found <= 1'b1;
          res_src   <= SRC_GLOBAL;
          if (extra && !gempty) begin
            global_head  <= global_head + 1'b1;
            global_count <= global_count - 1'b1;
            state        <= S_XDATA;
          end else begin
            state <= S_FIN;
          end
        end
        S_XDATA: begin
          pt    <= g_rd;
          state <= S_RPUT;
        end
        S_LDATA: begin
          res_task  <= l_rd;
          res_found <= 1'b1;
          res_src   <= SRC_LOCAL;
          state     <= S_FIN;
        end
        S_RPUT: begin
          if (cur_cnt[LOC_W]) begin
            cnt   <= '0;
            state <= S_SPRD;
          end else begin
            ring_tail[qp] <= cur_tail + 1'b1;
            state         <= S_FIN;
          end
        end
        S_SPRD: begin
          ring_head[qp] <= cur_head + 1'b1;
          state         <= S_SPWR;
        end
        S_SPWR: begin
          if (gfull) begin
            dropped <= 1'b1;
          end else begin
            global_count <= global_count + 1'b1;
          end
          if (cnt == HALF_W'(LOCAL_DEPTH / 2 - 1)) begin
            state <= S_RPUT;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_SPRD;
          end
        end
        S_STCHK: begin
          if (vic != a_proc && cur_nv) begin
            next_valid[qp] <= 1'b0;
            res_task       <= cur_nt;
            res_found      <= 1'b1;
            res_src        <= SRC_STOLEN;
            res_vic        <= vic;
            state          <= S_FIN;
          end else if (vic != a_proc && cur_cnt != '0) begin
            cnt   <= HALF_W'(steal_n - 1'b1);
            state <= S_STRD;
          end else if (si == np - 1'b1) begin
            state <= S_FIN;
          end else begin
            si  <= si + 1'b1;
            vic <= (vic_inc == {1'b0, np}) ? '0 : vic_inc[PROC_W-1:0];
          end
        end
        S_STRD: begin
          ring_head[qp] <= cur_head + 1'b1;
          state         <= S_STWR;
        end
        S_STWR: begin
          // the last task read from the victim is the one that runs
          if (cnt == '0) begin
            res_task  <= l_rd;
            res_found <= 1'b1;
            res_src   <= SRC_STOLEN;
            res_vic   <= vic;
            state     <= S_FIN;
          end else begin
            ring_tail[qp] <= cur_tail + 1'b1;
            cnt           <= cnt - 1'b1;
            state         <= S_STRD;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            found     <= res_found;
            out_task  <= res_task;
            source    <= res_src;
            victim    <= 2'(res_vic);
            overflow  <= dropped;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/wsrq_checker.sv =====
`timescale 1ns / 1ps
module wsrq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        found,
  input logic [15:0] out_task,
  input logic [1:0]  source,
  input logic [1:0]  victim
);
  import wsrq_pkg::*;

  // in_ready is low in the cycle after a request is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after a request was accepted");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> out_task == '0 && source == SRC_RUNNEXT && victim == 2'd0)
    else $error("result fields not zero when nothing was found");

  a_victim_only_on_steal: assert property (@(posedge clk) disable iff (rst)
    out_valid && source != SRC_STOLEN |-> victim == 2'd0)
    else $error("victim set on a result that was not stolen");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_task) && $stable(found))
    else $error("stalled result changed");

endmodule

bind work_stealing_run_queues_core wsrq_checker u_wsrq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .found     (found),
  .out_task  (out_task),
  .source    (source),
  .victim    (victim)
);

// ===== tb/work_stealing_run_queues_core_tb.sv =====
`timescale 1ns / 1ps
module work_stealing_run_queues_core_tb;
  import wsrq_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic        found;
    task_t       task_val;
    logic [1:0]  src;
    logic [1:0]  vic;
    logic        ovf;
  } dispatch_t;

  class dispatch_scoreboard;
    dispatch_t pending_q[$];
    int        errors;
    int        act_procs;
    task_t     ring[NUM_PROCS][LOCAL_DEPTH];
    int        rhead[NUM_PROCS];
    int        rtail[NUM_PROCS];
    task_t     gfifo[GLOBAL_DEPTH];
    int        ghead;
    int        gcount;
    bit        nvalid[NUM_PROCS];
    task_t     nslot[NUM_PROCS];
    int        tick[NUM_PROCS];
    bit        dropped;

    function new();
      errors = 0;
      act_procs = 4;
      ghead = 0;
      gcount = 0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        rhead[i] = 0;
        rtail[i] = 0;
        nvalid[i] = 0;
        nslot[i] = '0;
        tick[i] = 0;
      end
    endfunction

    function void gput(task_t t);
      if (gcount >= GLOBAL_DEPTH) begin
        dropped = 1;
        return;
      end
      gfifo[(ghead + gcount) % GLOBAL_DEPTH] = t;
      gcount++;
    endfunction

    function bit gtake(output task_t t);
      t = '0;
      if (gcount == 0) return 0;
      t = gfifo[ghead];
      ghead = (ghead + 1) % GLOBAL_DEPTH;
      gcount--;
      return 1;
    endfunction

    function int rcount(int p);
      return (rtail[p] + 2 * LOCAL_DEPTH - rhead[p]) % (2 * LOCAL_DEPTH);
    endfunction

    function void rput(int p, task_t t);
      int c;
      int n;
      c = rcount(p);
      if (c >= LOCAL_DEPTH) begin
        // full ring spills its older half to the global queue
        n = c / 2;
        for (int i = 0; i < n; i++) gput(ring[p][(rhead[p] + i) % LOCAL_DEPTH]);
        rhead[p] = (rhead[p] + n) % (2 * LOCAL_DEPTH);
      end
      ring[p][rtail[p] % LOCAL_DEPTH] = t;
      rtail[p] = (rtail[p] + 1) % (2 * LOCAL_DEPTH);
    endfunction

    function bit gfetch(int p, int extra, output task_t t);
      task_t x;
      if (!gtake(t)) return 0;
      for (int i = 0; i < extra; i++)
        if (gtake(x)) rput(p, x);
      return 1;
    endfunction

    function bit steal_from(int p, int v, output task_t t);
      int c;
      int n;
      int h;
      t = '0;
      if (nvalid[v]) begin
        t = nslot[v];
        nvalid[v] = 0;
        return 1;
      end
      c = rcount(v);
      if (c == 0) return 0;
      n = c - c / 2;
      if (n > LOCAL_DEPTH / 2) n = LOCAL_DEPTH / 2;
      h = rhead[v];
      for (int i = 0; i + 1 < n; i++) rput(p, ring[v][(h + i) % LOCAL_DEPTH]);
      t = ring[v][(h + n - 1) % LOCAL_DEPTH];
      rhead[v] = (h + n) % (2 * LOCAL_DEPTH);
      return 1;
    endfunction

    function void note_request(logic [1:0] act, logic [1:0] p_in, task_t tk, logic un);
      dispatch_t r;
      int p;
      int np;
      int v;
      task_t t;
      task_t old;
      r = '0;
      t = '0;
      p = p_in;
      dropped = 0;
      if (act == ACT_PUSH_LOCAL) begin
        t = tk;
        if (un) begin
          old = nslot[p];
          nslot[p] = tk;
          if (nvalid[p]) rput(p, old);
          nvalid[p] = 1;
        end else begin
          rput(p, t);
        end
        t = '0;
      end else if (act == ACT_PUSH_GLOBAL) begin
        gput(tk);
      end else if (act == ACT_FETCH) begin
        np = act_procs;
        if (np < 1) np = 1;
        if (np > NUM_PROCS) np = NUM_PROCS;
        tick[p] = (tick[p] + 1) % FAIR_PERIOD;
        if (tick[p] == 0 && gfetch(p, 1, t)) begin
          r.found = 1; r.src = SRC_GLOBAL;
        end else if (nvalid[p]) begin
          t = nslot[p];
          nvalid[p] = 0;
          r.found = 1; r.src = SRC_RUNNEXT;
        end else if (rcount(p) != 0) begin
          t = ring[p][rhead[p] % LOCAL_DEPTH];
          rhead[p] = (rhead[p] + 1) % (2 * LOCAL_DEPTH);
          r.found = 1; r.src = SRC_LOCAL;
        end else if (gfetch(p, (p == 0) ? 1 : 0, t)) begin
          r.found = 1; r.src = SRC_GLOBAL;
        end else if (np > 1) begin
          for (int i = 0; i < np && !r.found; i++) begin
            v = (p + i + 1) % np;
            if (v != p && steal_from(p, v, t)) begin
              r.found = 1; r.src = SRC_STOLEN; r.vic = 2'(v);
            end
          end
        end
        if (!r.found && gfetch(p, 0, t)) begin
          r.found = 1; r.src = SRC_GLOBAL;
        end
        if (!r.found) t = '0;
      end
      r.task_val = t;
      r.ovf = dropped;
      pending_q.push_back(r);
    endfunction

    function void check_result(dispatch_t got);
      dispatch_t e;
      if (pending_q.size() == 0) begin
        $error("unexpected result found=%0d task=%0h", got.found, got.task_val);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.found !== e.found) begin
        $error("found: expected %0d actual %0d", e.found, got.found); errors++;
      end
      if (got.task_val !== e.task_val) begin
        $error("out_task: expected %0h actual %0h", e.task_val, got.task_val); errors++;
      end
      if (got.src !== e.src) begin
        $error("source: expected %0d actual %0d", e.src, got.src); errors++;
      end
      if (got.vic !== e.vic) begin
        $error("victim: expected %0d actual %0d", e.vic, got.vic); errors++;
      end
      if (got.ovf !== e.ovf) begin
        $error("overflow: expected %0d actual %0d", e.ovf, got.ovf); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_data = '0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  action = '0;
  logic [1:0]  proc = '0;
  task_t       task_id = '0;
  logic        use_next = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic        found;
  task_t       out_task;
  logic [1:0]  source;
  logic [1:0]  victim;
  logic        overflow;

  dispatch_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off_req = 0;
  int cycle_cnt = 0;

  work_stealing_run_queues_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .action(action), .proc(proc),
    .task_id(task_id), .use_next(use_next), .out_valid(out_valid),
    .out_ready(out_ready), .found(found), .out_task(out_task), .source(source),
    .victim(victim), .overflow(overflow)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("work_stealing_run_queues_core verification failed");
      $finish;
    end
  end

  // result side: stalls at random, plus one long hold-off on request
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req && hold == 0) begin
        hold = 400;
        hold_off_req = 0;
      end
      if (hold > 0) begin
        out_ready = 0;
        hold--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result('{found, out_task, source, victim, overflow});
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(logic [1:0] a, logic [1:0] p, task_t t, logic u);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    action = a;
    proc = p;
    task_id = t;
    use_next = u;
    do @(posedge clk); while (!in_ready);
    sb.note_request(a, p, t, u);
    @(negedge clk);
    in_valid = 0;
  endtask

  task automatic drain_results();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_active_procs(logic [2:0] v);
    cfg_we = 1;
    cfg_data = v;
    @(negedge clk);
    cfg_we = 0;
    sb.act_procs = v;
  endtask

  task automatic random_requests(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      send_request(r < 35 ? ACT_PUSH_LOCAL : r < 75 ? ACT_FETCH :
                   r < 95 ? ACT_PUSH_GLOBAL : 2'd3,
                   2'($urandom_range(3)), task_t'($urandom), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: empty fetch, runnext displacement, steals, field extremes
    send_request(ACT_FETCH, 2'd0, 16'h0000, 1'b0);
    send_request(ACT_PUSH_LOCAL, 2'd1, 16'hFFFF, 1'b1);
    send_request(ACT_PUSH_LOCAL, 2'd1, 16'h0000, 1'b1);
    send_request(ACT_PUSH_LOCAL, 2'd1, 16'h5A5A, 1'b0);
    send_request(ACT_PUSH_LOCAL, 2'd1, 16'hA5A5, 1'b0);
    send_request(ACT_FETCH, 2'd0, 16'hFFFF, 1'b1);
    send_request(ACT_FETCH, 2'd2, 16'h0000, 1'b0);
    send_request(ACT_FETCH, 2'd3, 16'h0000, 1'b0);
    send_request(ACT_PUSH_GLOBAL, 2'd3, 16'h1234, 1'b1);
    send_request(ACT_PUSH_GLOBAL, 2'd2, 16'hFFFF, 1'b0);
    send_request(ACT_PUSH_GLOBAL, 2'd0, 16'h0001, 1'b0);
    send_request(ACT_FETCH, 2'd0, 16'h0000, 1'b0);
    send_request(ACT_FETCH, 2'd1, 16'h0000, 1'b0);
    send_request(2'd3, 2'd2, 16'hFFFF, 1'b1);
    send_request(ACT_FETCH, 2'd3, 16'h0000, 1'b0);
    send_request(ACT_FETCH, 2'd2, 16'h0000, 1'b0);
    send_request(ACT_FETCH, 2'd1, 16'h0000, 1'b0);
    drain_results();

    set_active_procs(3'd1);
    random_requests(90);
    drain_results();

    set_active_procs(3'd2);
    send_idle_pct = 46;
    random_requests(90);
    drain_results();

    set_active_procs(3'd4);
    send_idle_pct = 0;
    recv_stall_pct = 46;
    hold_off_req = 1;
    random_requests(90);
    drain_results();

    set_active_procs(3'd3);
    send_idle_pct = 23;
    recv_stall_pct = 23;
    random_requests(90);
    drain_results();

    set_active_procs(3'd0);
    random_requests(60);
    drain_results();

    set_active_procs(3'd7);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_requests(60);
    // ring spill on one processor, then peers steal big halves
    for (int i = 0; i < 270; i++)
      send_request(ACT_PUSH_LOCAL, 2'd1, task_t'($urandom), 1'b0);
    for (int i = 0; i < 40; i++)
      send_request(ACT_FETCH, 2'($urandom_range(3)), task_t'($urandom), 1'b0);
    drain_results();

    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("work_stealing_run_queues_core verification clean");
    end else begin
      $display("work_stealing_run_queues_core verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wsrq_pkg.sv
rtl/wsrq_ram.sv
rtl/work_stealing_run_queues_core.sv
rtl/wsrq_checker.sv
tb/work_stealing_run_queues_core_tb.sv
